@@ rtl/core/hrn_pkg.sv @@
// ----------------------------------------------------------------------------
// hrn_pkg: shared types and constants for the triangle area core
// Beat structures for the side and result channels, the square root width
// and the tag that rides along with the radicand.
// ----------------------------------------------------------------------------
package hrn_pkg;

	// Fixed field widths of the channel beats
	localparam int SIDE_W = 24;
	localparam int AREA_W = 48;

	// Radicand width and number of root digit steps
	localparam int SQ_W     = 100;
	localparam int SQ_STEPS = 50;

	typedef struct packed {
		logic [SIDE_W-1:0] side_a;
		logic [SIDE_W-1:0] side_b;
		logic [SIDE_W-1:0] side_c;
	} side_beat_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic              is_triangle;
	} area_beat_t;

	// Status that travels with the radicand through the root pipeline
	typedef struct packed {
		logic is_tri;
		logic sat;
	} sq_tag_t;

endpackage

@@ rtl/core/hrn_isqrt.sv @@
// ----------------------------------------------------------------------------
// hrn_isqrt: pipelined integer square root
// One restoring digit step per register stage, SQ_STEPS stages in all. A tag
// and a valid bit travel with each radicand; en freezes the whole pipe.
// ----------------------------------------------------------------------------
module hrn_isqrt
	import hrn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                rad_valid,
	input  logic [SQ_W-1:0]     rad,
	input  sq_tag_t             rad_tag,
	output logic                root_valid,
	output logic [SQ_W/2-1:0]   root,
	output sq_tag_t             root_tag
);

	logic [SQ_W-1:0] rem_s   [0:SQ_STEPS];
	logic [SQ_W-1:0] res_s   [0:SQ_STEPS];
	sq_tag_t         tag_s   [0:SQ_STEPS];
	logic            valid_s [0:SQ_STEPS];

	// Feed the first step from the input
	assign rem_s[0]   = rad;
	assign res_s[0]   = '0;
	assign tag_s[0]   = rad_tag;
	assign valid_s[0] = rad_valid;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

		logic [SQ_W-1:0] trial;
		logic            take;

		// Compare the remainder against the trial value
		assign trial = res_s[k] + BIT;
		assign take  = (rem_s[k] >= trial);

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		// Advance remainder, partial root and tag
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? (rem_s[k] - trial) : rem_s[k];
				res_s[k+1] <= take ? ((res_s[k] >> 1) + BIT) : (res_s[k] >> 1);
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign root_valid = valid_s[SQ_STEPS];
	assign root       = res_s[SQ_STEPS][SQ_W/2-1:0];
	assign root_tag   = tag_s[SQ_STEPS];

endmodule

@@ rtl/core/triangle_area_from_sides_core.sv @@
// Pipeline: 4 stages of adds and multiplies, 50 root digit stages and 1 output
// register. Throughput: one beat per cycle while the skid entry is empty; the
// single-step root stages set the rate, and a two-entry output buffer absorbs
// one stalled result beat.
// Reset clears all valid bits and the output buffer; data registers keep.
// ----------------------------------------------------------------------------
// triangle_area_from_sides_core: triangle area from three sides (Heron)
// Forms (a+b+c)(b+c-a)(a+c-b)(a+b-c) exactly, takes its integer square root
// and divides by four. Sides that fail the triangle test give area zero.
// ----------------------------------------------------------------------------
module triangle_area_from_sides_core
	import hrn_pkg::*;
#(
	parameter int SIDE_BITS = 24
)(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sides_valid,
	output logic       sides_stall,
	input  side_beat_t sides,
	output logic       result_valid,
	input  logic       result_stall,
	output area_beat_t result
);

	// Bits of each side in use, sum and factor widths, product split
	localparam int EW  = (SIDE_BITS < SIDE_W) ? SIDE_BITS : SIDE_W;
	localparam int SW  = EW + 2;
	localparam int FW  = EW + 1;
	localparam int MW  = SW + FW;
	localparam int HL  = (MW + 1) / 2;
	localparam int HH  = MW - HL;
	localparam int PW  = 2 * MW;
	localparam int PXW = (PW > SQ_W) ? PW : SQ_W;

	logic en;

	logic [EW-1:0] a, b, c;

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SW-1:0] sum_s1;
	logic [FW-1:0] fx_s1, fy_s1, fz_s1;
	logic          tri_s1, tri_s2, tri_s3, tri_s4;
	logic [MW-1:0] m1_s2, m2_s2;

	logic [2*HL-1:0]  pp_ll_s3;
	logic [HL+HH-1:0] pp_lh_s3, pp_hl_s3;
	logic [2*HH-1:0]  pp_hh_s3;
	logic [PW-1:0]    prod_s4;

	logic [PXW-1:0] prod_ext;
	sq_tag_t        rad_tag;

	logic              root_valid;
	logic [SQ_W/2-1:0] root;
	sq_tag_t           root_tag;
	area_beat_t        done;

	logic       out_valid_q, skid_valid_q;
	area_beat_t out_q, skid_q;
	logic       push, pop;

	// Hold the whole pipe while the skid entry is occupied
	assign en          = !skid_valid_q;
	assign sides_stall = skid_valid_q;

	// Keep only the low side bits in use
	assign a = sides.side_a[EW-1:0];
	assign b = sides.side_b[EW-1:0];
	assign c = sides.side_c[EW-1:0];

	// Valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sides_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: perimeter, the three factors and the triangle test
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= SW'(a) + SW'(b) + SW'(c);
			fx_s1  <= FW'(b) + FW'(c) - FW'(a);
			fy_s1  <= FW'(a) + FW'(c) - FW'(b);
			fz_s1  <= FW'(a) + FW'(b) - FW'(c);
			tri_s1 <= (FW'(b) + FW'(c) >= FW'(a)) &&
			          (FW'(a) + FW'(c) >= FW'(b)) &&
			          (FW'(a) + FW'(b) >= FW'(c));
		end
	end

	// Stage 2: two pairwise products
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2  <= MW'(sum_s1) * MW'(fx_s1);
			m2_s2  <= MW'(fy_s1) * MW'(fz_s1);
			tri_s2 <= tri_s1;
		end
	end

	// Stage 3: split the wide product into four partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s3 <= (2*HL)'(m1_s2[HL-1:0]) * (2*HL)'(m2_s2[HL-1:0]);
			pp_lh_s3 <= (HL+HH)'(m1_s2[HL-1:0]) * (HL+HH)'(m2_s2[MW-1:HL]);
			pp_hl_s3 <= (HL+HH)'(m1_s2[MW-1:HL]) * (HL+HH)'(m2_s2[HL-1:0]);
			pp_hh_s3 <= (2*HH)'(m1_s2[MW-1:HL]) * (2*HH)'(m2_s2[MW-1:HL]);
			tri_s3   <= tri_s2;
		end
	end

	// Stage 4: sum the partial products into the full radicand
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= PW'(pp_ll_s3) + (PW'(pp_lh_s3) << HL) + (PW'(pp_hl_s3) << HL) +
			           (PW'(pp_hh_s3) << (2 * HL));
			tri_s4  <= tri_s3;
		end
	end

	// Flag a radicand beyond the root range
	assign prod_ext       = PXW'(prod_s4);
	assign rad_tag.is_tri = tri_s4;
	assign rad_tag.sat    = ((prod_ext >> SQ_W) != '0);

	hrn_isqrt u_isqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.rad_valid  (valid_s4),
		.rad        (prod_ext[SQ_W-1:0]),
		.rad_tag    (rad_tag),
		.root_valid (root_valid),
		.root       (root),
		.root_tag   (root_tag)
	);

	// Divide the root by four, saturate or drop to zero as flagged
	always_comb begin
		done.is_triangle = root_tag.is_tri;
		if (!root_tag.is_tri) begin
			done.area = '0;
		end else if (root_tag.sat) begin
			done.area = '1;
		end else begin
			done.area = AREA_W'(root[SQ_W/2-1:2]);
		end
	end

	// Output register with one skid entry behind it
	assign push = en && root_valid;
	assign pop  = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : done;
		end else if (push) begin
			skid_q <= done;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the triangle area core
// Sends side triples and checks every result beat against a local Heron
// predictor: exact product of the four factors, bitwise integer square root,
// divide by four. Covers directed corners, constructed triangles, broken
// triples, drained pauses and four mixes of sender gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top
	import hrn_pkg::*;
();

	localparam int  WATCHDOG_CYCLES = 2000;
	localparam int  DRAIN_CYCLES    = 60;
	localparam int  MAX_REPORTS     = 10;
	localparam longint SIDE_MAX     = (longint'(1) << SIDE_W) - 1;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       sides_valid  = 1'b0;
	logic       sides_stall;
	side_beat_t sides        = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	area_beat_t result;

	// Pending areas in acceptance order
	area_beat_t pending_areas[$];

	int idle_pct  = 0;
	int stall_pct = 0;
	int error_count    = 0;
	int sent_count     = 0;
	int non_tri_count  = 0;
	int flat_count     = 0;
	int checked_count  = 0;
	int quiet_cycles   = 0;

	triangle_area_from_sides_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sides_valid  (sides_valid),
		.sides_stall  (sides_stall),
		.sides        (sides),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Area by Heron's formula, twice the fraction bits of the sides, truncated
	function automatic area_beat_t heron_area(side_beat_t s);
		logic [25:0]  a, b, c;
		logic [127:0] prod, root, cand;
		area_beat_t   r;
		a = 26'(s.side_a);
		b = 26'(s.side_b);
		c = 26'(s.side_c);
		r = '0;
		if (b + c < a || a + c < b || a + b < c) begin
			return r;
		end
		r.is_triangle = 1'b1;
		prod = 128'(a + b + c) * 128'(b + c - a) * 128'(a + c - b) * 128'(a + b - c);
		if ((prod >> SQ_W) != 0) begin
			r.area = '1;
			return r;
		end
		// build the root one bit at a time from the top
		root = '0;
		for (int i = SQ_STEPS - 1; i >= 0; i--) begin
			cand = root | (128'(1) << i);
			if (cand * cand <= prod)
				root = cand;
		end
		root = root >> 2;
		if ((root >> AREA_W) != 0)
			r.area = '1;
		else
			r.area = root[AREA_W-1:0];
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] rand_side();
		int w;
		w = $urandom_range(1, SIDE_W);
		return SIDE_W'($urandom) >> (SIDE_W - w);
	endfunction

	task automatic log_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	// Send one beat, with random gaps ahead of it; valid stays up on return
	task automatic send_sides(side_beat_t s);
		area_beat_t exp_area;
		while ($urandom_range(0, 99) < idle_pct) begin
			sides_valid <= 1'b0;
			@(posedge clk);
		end
		sides_valid <= 1'b1;
		sides       <= s;
		@(posedge clk);
		while (sides_stall)
			@(posedge clk);
		exp_area = heron_area(s);
		pending_areas.push_back(exp_area);
		sent_count++;
		if (!exp_area.is_triangle)
			non_tri_count++;
		else if (exp_area.area == '0)
			flat_count++;
	endtask

	task automatic send_abc(longint a, longint b, longint c);
		side_beat_t s;
		s.side_a = SIDE_W'(a);
		s.side_b = SIDE_W'(b);
		s.side_c = SIDE_W'(c);
		send_sides(s);
	endtask

	// Drop valid and hold until every pending area has come back
	task automatic wait_drained();
		sides_valid <= 1'b0;
		while (pending_areas.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_abc(0, 0, 0);
		send_abc(SIDE_MAX, SIDE_MAX, SIDE_MAX);
		send_abc(SIDE_MAX, SIDE_MAX, SIDE_MAX - 1);
		send_abc(SIDE_MAX, SIDE_MAX, 1);
		send_abc(SIDE_MAX, SIDE_MAX, 0);
		send_abc(3 << 8, 4 << 8, 5 << 8);
		send_abc(1, 1, 1);
		// one side longer than the other two together, in each slot
		send_abc(SIDE_MAX, 0, 0);
		send_abc(0, SIDE_MAX, 0);
		send_abc(0, 0, SIDE_MAX);
		send_abc(1000, 300, 699);
		send_abc(300, 1000, 699);
		send_abc(300, 699, 1000);
		// flat triangles, one side equal to the sum of the others, then two isosceles ones
		send_abc(24'hAAAAAA, 24'h555555, 24'h555555);
		send_abc(24'h555555, 24'hAAAAAA, 24'h555555);
		send_abc(10, 4, 6);
		send_abc(24'hFFFF00, 24'h000100, 24'hFFFF00);
		send_abc(24'h800000, 24'h800000, 24'h7FFFFF);
	endtask

	task automatic test_random_mix(int n, int idle, int stall);
		longint a, b, c, lo, hi, t;
		int     pick;
		idle_pct  = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			a = rand_side();
			b = rand_side();
			if (pick < 75) begin
				// valid triangle: third side between the difference and the sum
				lo = (a > b) ? a - b : b - a;
				hi = a + b;
				if (hi > SIDE_MAX)
					hi = SIDE_MAX;
				c = lo + $urandom_range(0, 32'(hi - lo));
			end else if (pick < 90) begin
				a = SIDE_W'($urandom);
				b = SIDE_W'($urandom);
				c = SIDE_W'($urandom);
			end else begin
				// broken triple: one side past the sum of the other two
				b = b >> 2;
				c = rand_side() >> 2;
				t = a;
				a = b + c + 1 + $urandom_range(0, 1000);
				if (a > SIDE_MAX)
					a = t;
			end
			// rotate so every slot sees every role
			case ($urandom_range(0, 2))
				0: send_abc(a, b, c);
				1: send_abc(b, c, a);
				default: send_abc(c, a, b);
			endcase
		end
	endtask

	task automatic test_drain_pause();
		test_random_mix(20, 0, 0);
		wait_drained();
		test_random_mix(20, 0, 62);
		wait_drained();
	endtask

	// Drive the result stall at the current rate
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Compare each result beat with the oldest pending area
	always @(posedge clk) begin
		area_beat_t exp_area;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_areas.size() == 0) begin
				log_error($sformatf("result beat with nothing pending: area=%h flag=%b",
					result.area, result.is_triangle));
			end else begin
				exp_area = pending_areas.pop_front();
				checked_count++;
				if (result.area !== exp_area.area)
					log_error($sformatf("beat %0d area: expected %h, got %h",
						checked_count, exp_area.area, result.area));
				if (result.is_triangle !== exp_area.is_triangle)
					log_error($sformatf("beat %0d is_triangle: expected %b, got %b",
						checked_count, exp_area.is_triangle, result.is_triangle));
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((sides_valid && !sides_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("ERROR: no beat moved in %0d cycles, %0d results pending",
				WATCHDOG_CYCLES, pending_areas.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(260, 0, 0);
		test_random_mix(260, 62, 0);
		test_drain_pause();
		test_random_mix(260, 0, 62);
		test_random_mix(260, 11, 11);

		// drain, then watch for stray beats
		wait_drained();
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_areas.size() != 0)
			log_error($sformatf("%0d results never arrived", pending_areas.size()));

		$display("Sent %0d side triples (%0d not triangles, %0d flat), checked %0d areas",
			sent_count, non_tri_count, flat_count, checked_count);
		$display("under no idling, sender gaps, result stalls, both, and drained pauses");
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d errors", error_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
